>>> design/fca_pkg.sv
// Shared constants, types and window tables for the four-colour ant grid step block.
package fca_pkg;

  localparam int START_SIDE  = 9;
  localparam int MAX_GROWTHS = 4;
  localparam int GRID_SIDE   = START_SIDE * 81;
  localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W      = 20;
  localparam int COORD_W     = 10;
  localparam int LEVEL_W     = 3;
  localparam int START_POS   = (GRID_SIDE - 1) / 2;
  localparam int START_ADDR  = START_POS * GRID_SIDE + START_POS;

  // Heading codes
  localparam logic [1:0] HEAD_PX = 2'd0;
  localparam logic [1:0] HEAD_NY = 2'd1;
  localparam logic [1:0] HEAD_NX = 2'd2;
  localparam logic [1:0] HEAD_PY = 2'd3;

  localparam logic [1:0] START_HEADING = HEAD_NY;
  localparam logic [3:0] TURN_RULE_RESET = 4'd14;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [1:0]         color_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    color_t wr_data;
  } mem_req_t;

  // Lowest physical coordinate inside the window at a given growth level
  function automatic coord_t win_lo(input level_t level);
    coord_t lo;
    case (level)
      3'd0:    lo = COORD_W'((GRID_SIDE - START_SIDE) / 2);
      3'd1:    lo = COORD_W'((GRID_SIDE - START_SIDE * 3) / 2);
      3'd2:    lo = COORD_W'((GRID_SIDE - START_SIDE * 9) / 2);
      3'd3:    lo = COORD_W'((GRID_SIDE - START_SIDE * 27) / 2);
      default: lo = COORD_W'(0);
    endcase
    return lo;
  endfunction

  // Highest physical coordinate inside the window at a given growth level
  function automatic coord_t win_hi(input level_t level);
    coord_t hi;
    case (level)
      3'd0:    hi = COORD_W'((GRID_SIDE - START_SIDE) / 2 + START_SIDE - 1);
      3'd1:    hi = COORD_W'((GRID_SIDE - START_SIDE * 3) / 2 + START_SIDE * 3 - 1);
      3'd2:    hi = COORD_W'((GRID_SIDE - START_SIDE * 9) / 2 + START_SIDE * 9 - 1);
      3'd3:    hi = COORD_W'((GRID_SIDE - START_SIDE * 27) / 2 + START_SIDE * 27 - 1);
      default: hi = COORD_W'(GRID_SIDE - 1);
    endcase
    return hi;
  endfunction

endpackage

>>> design/fca_if.sv
// Channel interfaces: tick input, cell result output and turn rule write.
interface fca_tick_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

interface fca_cell_if;
  logic                 valid;
  logic                 ready;
  fca_pkg::coord_t      cell_x;
  fca_pkg::coord_t      cell_y;
  fca_pkg::color_t      cell_color;
  logic [1:0]           heading;
  fca_pkg::level_t      window_level;
  logic                 grew;
  logic                 halted;
  modport source (output valid, output cell_x, output cell_y, output cell_color,
                  output heading, output window_level, output grew, output halted,
                  input ready);
  modport sink (input valid, input cell_x, input cell_y, input cell_color,
                input heading, input window_level, input grew, input halted,
                output ready);
endinterface

interface fca_rule_if;
  logic       valid;
  logic       ready;
  logic [3:0] turn_rule;
  modport source (output valid, output turn_rule, input ready);
  modport sink (input valid, input turn_rule, output ready);
endinterface

>>> design/fca_cell_mem.sv
// Cell colour store: one write port, one registered read port.
module fca_cell_mem (
  input  logic              clk,
  input  fca_pkg::mem_req_t req,
  output fca_pkg::color_t   rd_data
);

  fca_pkg::color_t mem [fca_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/fca_ant_core.sv
// Ant state, clearing sweep and read-modify-write of the cell store.
module fca_ant_core (
  input  logic              clk,
  input  logic              rst,
  fca_tick_if.sink          tick,
  fca_cell_if.source        result,
  fca_rule_if.sink          rule,
  output fca_pkg::mem_req_t req,
  input  fca_pkg::color_t   rd_data
);

  logic                 clearing;
  fca_pkg::addr_t       clr_addr;
  logic                 s1_valid;
  fca_pkg::coord_t      ant_x;
  fca_pkg::coord_t      ant_y;
  fca_pkg::addr_t       ant_addr;
  logic [1:0]           ant_heading;
  fca_pkg::level_t      level;
  logic                 stopped;
  logic [3:0]           turn_rule;

  logic                 tick_acc;
  logic                 commit;
  logic [1:0]           h_new;
  fca_pkg::color_t      col_new;
  fca_pkg::coord_t      lo;
  fca_pkg::coord_t      hi;
  logic                 leave;
  logic                 at_max;
  fca_pkg::coord_t      x_next;
  fca_pkg::coord_t      y_next;
  fca_pkg::addr_t       addr_next;

  assign tick.ready = !clearing && !s1_valid;
  assign tick_acc   = tick.valid && tick.ready;
  assign commit     = s1_valid && (!result.valid || result.ready);
  assign rule.ready = 1'b1;

  assign h_new   = ant_heading + (turn_rule[rd_data] ? 2'd1 : 2'd3);
  assign col_new = rd_data + 2'd1;
  assign lo      = fca_pkg::win_lo(level);
  assign hi      = fca_pkg::win_hi(level);
  assign at_max  = level >= fca_pkg::LEVEL_W'(fca_pkg::MAX_GROWTHS);

  always_comb begin
    leave     = 1'b0;
    x_next    = ant_x;
    y_next    = ant_y;
    addr_next = ant_addr;
    unique case (h_new)
      fca_pkg::HEAD_PX: begin
        leave     = (ant_x == hi);
        x_next    = ant_x + fca_pkg::COORD_W'(1);
        addr_next = ant_addr + fca_pkg::ADDR_W'(1);
      end
      fca_pkg::HEAD_NY: begin
        leave     = (ant_y == lo);
        y_next    = ant_y - fca_pkg::COORD_W'(1);
        addr_next = ant_addr - fca_pkg::ADDR_W'(fca_pkg::GRID_SIDE);
      end
      fca_pkg::HEAD_NX: begin
        leave     = (ant_x == lo);
        x_next    = ant_x - fca_pkg::COORD_W'(1);
        addr_next = ant_addr - fca_pkg::ADDR_W'(1);
      end
      fca_pkg::HEAD_PY: begin
        leave     = (ant_y == hi);
        y_next    = ant_y + fca_pkg::COORD_W'(1);
        addr_next = ant_addr + fca_pkg::ADDR_W'(fca_pkg::GRID_SIDE);
      end
      default: begin
        leave = 1'b0;
      end
    endcase
  end

  // Sweep zeros through the store after reset, then serve the ant
  always_comb begin
    req.rd_en   = tick_acc && tick.advance;
    req.rd_addr = ant_addr;
    if (clearing) begin
      req.wr_en   = 1'b1;
      req.wr_addr = clr_addr;
      req.wr_data = '0;
    end else begin
      req.wr_en   = commit && !stopped;
      req.wr_addr = ant_addr;
      req.wr_data = col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_addr     <= '0;
      s1_valid     <= 1'b0;
      ant_x        <= fca_pkg::COORD_W'(fca_pkg::START_POS);
      ant_y        <= fca_pkg::COORD_W'(fca_pkg::START_POS);
      ant_addr     <= fca_pkg::ADDR_W'(fca_pkg::START_ADDR);
      ant_heading  <= fca_pkg::START_HEADING;
      level        <= '0;
      stopped      <= 1'b0;
      turn_rule    <= fca_pkg::TURN_RULE_RESET;
      result.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + fca_pkg::ADDR_W'(1);
        if (clr_addr == fca_pkg::ADDR_W'(fca_pkg::CELL_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (rule.valid) begin
        turn_rule <= rule.turn_rule;
      end
      // Drop ticks with advance clear: they cause no transaction
      if (tick_acc && tick.advance) begin
        s1_valid <= 1'b1;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (commit && !stopped) begin
        ant_heading <= h_new;
        if (leave && at_max) begin
          stopped <= 1'b1;
        end else begin
          ant_x    <= x_next;
          ant_y    <= y_next;
          ant_addr <= addr_next;
          if (leave) begin
            level <= level + fca_pkg::LEVEL_W'(1);
          end
        end
      end
    end
  end

  // Result payload: coordinates in the window as it stood before this tick
  always_ff @(posedge clk) begin
    if (commit) begin
      result.cell_x <= ant_x - lo;
      result.cell_y <= ant_y - lo;
      if (stopped) begin
        result.cell_color   <= rd_data;
        result.heading      <= ant_heading;
        result.window_level <= level;
        result.grew         <= 1'b0;
        result.halted       <= 1'b1;
      end else begin
        result.cell_color   <= col_new;
        result.heading      <= h_new;
        result.window_level <= (leave && !at_max) ? level + fca_pkg::LEVEL_W'(1) : level;
        result.grew         <= leave && !at_max;
        result.halted       <= leave && at_max;
      end
    end
  end

endmodule

>>> design/four_color_ant_grid_step_top.sv
// Top level of the four-colour ant grid step block.
// Channels: tick (sink) carries one advance item per transaction; result
// (source) returns one result per tick whose advance bit is set; rule
// (sink) writes the 4-bit turn rule and is always ready.
// After reset the block sweeps zeros through the 531441-cell store, one
// cell a cycle, so tick.ready stays low until it is done; rule writes are
// taken during the sweep. The ant starts at the grid centre heading -y and
// the turn rule resets to 14.
// An accepted tick reads its cell on the accepting edge; once the output
// register is free the result is registered there. No new tick is taken
// while one waits to commit, as the read-modify-write loop on the cell
// store sets the pace (the next address depends on the colour just read).
// A tick with advance clear is consumed and gives no result.
// When result.ready is low the result holds in the output register; one
// further tick may be accepted and waits, with its read data held, until
// the output register frees. Once halted the block repeats the ant's cell
// on every tick and changes nothing.
module four_color_ant_grid_step_top (
  input logic        clk,
  input logic        rst,
  fca_tick_if.sink   tick,
  fca_cell_if.source result,
  fca_rule_if.sink   rule
);

  fca_pkg::mem_req_t req;
  fca_pkg::color_t   rd_data;

  fca_ant_core u_core (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .result  (result),
    .rule    (rule),
    .req     (req),
    .rd_data (rd_data)
  );

  fca_cell_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the four-colour ant grid step block: ticks, turn rules, growth and halt.
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 36;

  typedef struct packed {
    fca_pkg::coord_t x;
    fca_pkg::coord_t y;
    fca_pkg::color_t colour;
    logic [1:0]      heading;
    fca_pkg::level_t level;
    logic            grew;
    logic            halted;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst;

  fca_tick_if tick_ch ();
  fca_cell_if cell_ch ();
  fca_rule_if rule_ch ();

  four_color_ant_grid_step_top dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (cell_ch),
    .rule   (rule_ch)
  );

  // Shadow copy of the grid, the ant and the turn rule
  bit [1:0]   colour_grid [fca_pkg::CELL_COUNT];
  int         ant_x;
  int         ant_y;
  int         ant_level;
  logic [1:0] ant_heading;
  logic       ant_halted;
  logic [3:0] rule_shadow;

  cell_result_t expected_cells [$];

  bit no_idle;
  int failures;
  int ticks_sent;
  int blank_ticks;
  int results_seen;
  int rule_writes;
  int growths;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #24_000_000;
    $display("timeout with %0d results still outstanding", expected_cells.size());
    $display("testbench failed");
    $finish;
  end

  function automatic int window_side(input int level);
    int side;
    side = fca_pkg::START_SIDE;
    for (int i = 0; i < level; i++) side *= 3;
    return side;
  endfunction

  // Turn, recolour and move the shadow ant; queue the cell the block must report
  task automatic step_ant();
    int              lo;
    int              side;
    int              nx;
    int              ny;
    int              addr;
    fca_pkg::color_t colour;
    cell_result_t    res;
    side   = window_side(ant_level);
    lo     = (fca_pkg::GRID_SIDE - side) / 2;
    addr   = ant_y * fca_pkg::GRID_SIDE + ant_x;
    res.x  = fca_pkg::coord_t'(ant_x - lo);
    res.y  = fca_pkg::coord_t'(ant_y - lo);
    res.grew = 1'b0;
    colour = colour_grid[addr];
    if (!ant_halted) begin
      ant_heading = rule_shadow[colour] ? ant_heading + 2'd1 : ant_heading - 2'd1;
      colour = colour + 2'd1;
      colour_grid[addr] = colour;
      nx = ant_x;
      ny = ant_y;
      case (ant_heading)
        fca_pkg::HEAD_PX: nx = ant_x + 1;
        fca_pkg::HEAD_NY: ny = ant_y - 1;
        fca_pkg::HEAD_NX: nx = ant_x - 1;
        fca_pkg::HEAD_PY: ny = ant_y + 1;
      endcase
      if (nx < lo || nx >= lo + side || ny < lo || ny >= lo + side) begin
        // the largest window cannot grow: stay put and stop for good
        if (ant_level >= fca_pkg::MAX_GROWTHS) begin
          ant_halted = 1'b1;
        end else begin
          ant_level++;
          growths++;
          res.grew = 1'b1;
          ant_x = nx;
          ant_y = ny;
        end
      end else begin
        ant_x = nx;
        ant_y = ny;
      end
    end
    res.colour  = colour;
    res.heading = ant_heading;
    res.level   = fca_pkg::level_t'(ant_level);
    res.halted  = ant_halted;
    expected_cells.push_back(res);
  endtask

  task automatic send_tick(input logic adv);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.advance <= adv;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    if (adv) begin
      ticks_sent++;
      step_ant();
    end else begin
      blank_ticks++;
    end
  endtask

  // Drop valid, let every outstanding result arrive, then let the pipeline settle
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_turn_rule(input logic [3:0] rule);
    wait_drained();
    rule_ch.valid     <= 1'b1;
    rule_ch.turn_rule <= rule;
    do @(posedge clk); while (rule_ch.ready !== 1'b1);
    rule_ch.valid <= 1'b0;
    rule_shadow = rule;
    rule_writes++;
  endtask

  task automatic compare_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  initial begin : cell_checker
    cell_result_t want;
    cell_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1) begin
        if (expected_cells.size() == 0) begin
          $error("cell result with no tick outstanding: x %0d y %0d colour %0d",
                 cell_ch.cell_x, cell_ch.cell_y, cell_ch.cell_color);
          failures++;
        end else begin
          want = expected_cells.pop_front();
          results_seen++;
          compare_field("cell_x", want.x, cell_ch.cell_x);
          compare_field("cell_y", want.y, cell_ch.cell_y);
          compare_field("cell_color", want.colour, cell_ch.cell_color);
          compare_field("heading", want.heading, cell_ch.heading);
          compare_field("window_level", want.level, cell_ch.window_level);
          compare_field("grew", want.grew, cell_ch.grew);
          compare_field("halted", want.halted, cell_ch.halted);
        end
      end
      cell_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic test_reset();
    rst               <= 1'b1;
    tick_ch.valid     <= 1'b0;
    tick_ch.advance   <= 1'b0;
    rule_ch.valid     <= 1'b0;
    rule_ch.turn_rule <= 4'd0;
    ant_x       = fca_pkg::START_POS;
    ant_y       = fca_pkg::START_POS;
    ant_level   = 0;
    ant_heading = fca_pkg::START_HEADING;
    ant_halted  = 1'b0;
    rule_shadow = fca_pkg::TURN_RULE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Reset rule first, then blank ticks, both uniform rules and a mixed rule
  task automatic test_directed();
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    write_turn_rule(4'h0);
    repeat (4) send_tick(1'b1);
    write_turn_rule(4'hF);
    repeat (4) send_tick(1'b1);
    write_turn_rule(4'b0110);
    repeat (6) send_tick(1'b1);
  endtask

  task automatic test_random_rules();
    int issued;
    int burst;
    issued = 0;
    for (int phase = 0; issued < 1000; phase++) begin
      write_turn_rule(4'($urandom_range(15)));
      no_idle = (phase == 3);
      burst = $urandom_range(150, 30);
      repeat (burst) begin
        if ($urandom_range(9) == 0) begin
          send_tick(1'b0);
        end else begin
          send_tick(1'b1);
          issued++;
        end
        if ($urandom_range(99) == 0) wait_drained();
      end
    end
    no_idle = 1'b0;
  endtask

  // Alternate right and left turns: the ant walks a staircase through every growth to the edge
  task automatic test_steer_to_edge();
    for (int n = 0; n < 2000 && !ant_halted; n++) begin
      write_turn_rule(n[0] ? 4'h0 : 4'hF);
      send_tick(1'b1);
    end
  endtask

  task automatic test_after_halt();
    write_turn_rule(4'($urandom_range(15)));
    repeat (20) send_tick($urandom_range(3) != 0);
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random_rules();
    test_steer_to_edge();
    test_after_halt();
    wait_drained();
    $display("ran %0d ticks and %0d blank ticks over %0d turn rules; %0d results checked",
             ticks_sent, blank_ticks, rule_writes, results_seen);
    $display("window grew %0d times, final level %0d, ant halted %0d",
             growths, ant_level, ant_halted);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
